[rtl/core/rmj_pkg.sv]
// Shared types and constants for the radar measurement Jacobian pipeline.
`timescale 1ns / 1ps
package rmj_pkg;

  localparam int unsigned DataW     = 32;   // Q15.16 word
  localparam int unsigned FracW     = 16;
  localparam int unsigned CfgW      = 31;
  localparam logic [CfgW-1:0] CfgReset = CfgW'(7);

  localparam int unsigned RadW      = 2 * DataW;      // range squared
  localparam int unsigned SqrtSteps = RadW / 2;       // one root bit per stage
  localparam int unsigned QuoW      = DataW;          // quotient bits kept
  localparam int unsigned DenW      = 3 * DataW;      // r2 * r
  localparam int unsigned NumW      = 3 * DataW + FracW;
  localparam int unsigned RemW      = DenW + QuoW;

  typedef struct packed {
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] range_by_px;
    logic signed [DataW-1:0] range_by_py;
    logic signed [DataW-1:0] bearing_by_px;
    logic signed [DataW-1:0] bearing_by_py;
    logic signed [DataW-1:0] rate_by_px;
    logic signed [DataW-1:0] rate_by_py;
    logic                    too_close;
  } out_t;

endpackage

[rtl/core/radar_measurement_jacobian.sv]
// Top level: EKF radar measurement Jacobian, fully pipelined.
//
//   channel  | signals                          | payload
//   ---------+----------------------------------+----------------------------
//   in       | in_valid_i / in_ready_o          | in_data_i  (rmj_pkg::in_t)
//   out      | out_valid_o / out_ready_i        | out_data_o (rmj_pkg::out_t)
//   config   | cfg_we_i                         | cfg_wdata_i (min_range_squared)
//
// One beat enters per cycle while in_ready_o is high. The latency is set by
// the 32-stage square root and the 33-stage dividers that follow it in series.
// All stages advance together whenever the output skid slot is empty, so a
// stall holds every beat in place; the skid slot lets one more beat in while
// a finished result waits. Reset clears the valid bits and loads the
// threshold with 7; the data registers are not reset.
`timescale 1ns / 1ps
module radar_measurement_jacobian (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  rmj_pkg::in_t             in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output rmj_pkg::out_t            out_data_o,
  input  logic                     cfg_we_i,
  input  logic [rmj_pkg::CfgW-1:0] cfg_wdata_i
);
  import rmj_pkg::*;

  localparam int unsigned DivLat = QuoW + 1;

  typedef struct packed {
    logic [RadW-1:0]  r2;
    logic [RadW-1:0]  cmag;
    logic             ncr;
    logic             tc;
    logic [DataW-1:0] mpx;
    logic [DataW-1:0] mpy;
    logic             npx;
    logic             npy;
  } side_t;

  typedef struct packed {
    logic [5:0] neg;
    logic       tc;
  } tag_t;

  function automatic logic [DataW-1:0] mag_f(input logic [DataW-1:0] v);
    return v[DataW-1] ? (~v + DataW'(1)) : v;
  endfunction

  // Clamp the magnitude, then apply the sign.
  function automatic logic [DataW-1:0] sat_f(input logic neg, input logic ovf,
                                             input logic [DataW-1:0] q);
    logic [DataW-1:0] lim, m;
    lim = neg ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
    m   = (ovf || (q > lim)) ? lim : q;
    return neg ? (~m + DataW'(1)) : m;
  endfunction

  logic             pipe_en;
  logic [CfgW-1:0]  thr_q;

  // Stage 1: magnitudes and signs.
  logic             v1_q;
  logic [DataW-1:0] mpx1_q, mpy1_q, mvx1_q, mvy1_q;
  logic             npx1_q, npy1_q, nvx1_q, nvy1_q;
  // Stage 2: products.
  logic             v2_q;
  logic [RadW-1:0]  pxx2_q, pyy2_q, p1_2_q, p2_2_q;
  logic             n1_2_q, n2_2_q, npx2_q, npy2_q;
  logic [DataW-1:0] mpx2_q, mpy2_q;
  // Stage 3: range squared, cross term, range check.
  logic             v3_q;
  side_t            s3_q, s3_d;
  // Square root delay line.
  logic             sv_q [0:SqrtSteps-1];
  side_t            sd_q [0:SqrtSteps-1];
  logic [DataW-1:0] root;
  // Partial products.
  logic             va_q;
  side_t            sa_q;
  logic [DataW-1:0] sqa_q;
  logic [RadW-1:0]  dlo_q, dhi_q, ylo_q, yhi_q, xlo_q, xhi_q;
  // Sums and divider operands.
  logic             vb_q;
  logic [DataW-1:0] mpxb_q, mpyb_q, sqb_q;
  logic [RadW-1:0]  r2b_q;
  logic [DenW-1:0]  denb_q, nyb_q, nxb_q;
  tag_t             tagb_q;
  // Divider delay line.
  logic             dv_q   [0:DivLat-1];
  tag_t             dtag_q [0:DivLat-1];
  logic [NumW-1:0]  num [0:5];
  logic [DenW-1:0]  den [0:5];
  logic [QuoW-1:0]  quo [0:5];
  logic             ovf [0:5];
  // Result stage and output slots.
  logic             res_vq;
  out_t             res_q, res_d;
  logic             out_vq, skid_vq;
  out_t             out_q, skid_q;

  assign pipe_en    = !skid_vq;
  assign in_ready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= CfgReset;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Stage 1
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mpx1_q <= mag_f(in_data_i.pos_x);
      mpy1_q <= mag_f(in_data_i.pos_y);
      mvx1_q <= mag_f(in_data_i.vel_x);
      mvy1_q <= mag_f(in_data_i.vel_y);
      npx1_q <= in_data_i.pos_x[DataW-1];
      npy1_q <= in_data_i.pos_y[DataW-1];
      nvx1_q <= in_data_i.vel_x[DataW-1];
      nvy1_q <= in_data_i.vel_y[DataW-1];
    end
  end

  // Stage 2: four 32x32 products
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pxx2_q <= mpx1_q * mpx1_q;
      pyy2_q <= mpy1_q * mpy1_q;
      p1_2_q <= mvx1_q * mpy1_q;
      p2_2_q <= mpx1_q * mvy1_q;
      n1_2_q <= nvx1_q ^ npy1_q;
      n2_2_q <= npx1_q ^ nvy1_q;
      npx2_q <= npx1_q;
      npy2_q <= npy1_q;
      mpx2_q <= mpx1_q;
      mpy2_q <= mpy1_q;
    end
  end

  // Stage 3: cross = vx*py - px*vy as sign and magnitude
  logic signed [RadW+1:0] sp1, sp2, diff;
  logic        [RadW+1:0] ndiff;
  always_comb begin
    sp1        = n1_2_q ? -$signed({2'b00, p1_2_q}) : $signed({2'b00, p1_2_q});
    sp2        = n2_2_q ? -$signed({2'b00, p2_2_q}) : $signed({2'b00, p2_2_q});
    diff       = sp1 - sp2;
    ndiff      = -diff;
    s3_d.r2    = pxx2_q + pyy2_q;
    s3_d.ncr   = diff[RadW+1];
    s3_d.cmag  = s3_d.ncr ? ndiff[RadW-1:0] : diff[RadW-1:0];
    s3_d.tc    = (s3_d.r2 == '0) || (s3_d.r2 < (RadW'(thr_q) << FracW));
    s3_d.mpx   = mpx2_q;
    s3_d.mpy   = mpy2_q;
    s3_d.npx   = npx2_q;
    s3_d.npy   = npy2_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s3_q <= s3_d;
    end
  end

  rmj_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .rad_i  (s3_q.r2),
    .root_o (root)
  );

  // Carry side data alongside the root stages.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sd_q[0] <= s3_q;
      for (int j = 1; j < SqrtSteps; j++) begin
        sd_q[j] <= sd_q[j-1];
      end
    end
  end

  // Partial products: r2 * r, py * cross, px * cross in 32x32 pieces
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sa_q  <= sd_q[SqrtSteps-1];
      sqa_q <= root;
      dlo_q <= sd_q[SqrtSteps-1].r2[DataW-1:0]     * root;
      dhi_q <= sd_q[SqrtSteps-1].r2[RadW-1:DataW]  * root;
      ylo_q <= sd_q[SqrtSteps-1].mpy * sd_q[SqrtSteps-1].cmag[DataW-1:0];
      yhi_q <= sd_q[SqrtSteps-1].mpy * sd_q[SqrtSteps-1].cmag[RadW-1:DataW];
      xlo_q <= sd_q[SqrtSteps-1].mpx * sd_q[SqrtSteps-1].cmag[DataW-1:0];
      xhi_q <= sd_q[SqrtSteps-1].mpx * sd_q[SqrtSteps-1].cmag[RadW-1:DataW];
    end
  end

  // Sum the pieces; fix each entry's sign now.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mpxb_q     <= sa_q.mpx;
      mpyb_q     <= sa_q.mpy;
      sqb_q      <= sqa_q;
      r2b_q      <= sa_q.r2;
      denb_q     <= DenW'(dlo_q) + {dhi_q, {DataW{1'b0}}};
      nyb_q      <= DenW'(ylo_q) + {yhi_q, {DataW{1'b0}}};
      nxb_q      <= DenW'(xlo_q) + {xhi_q, {DataW{1'b0}}};
      tagb_q.tc  <= sa_q.tc;
      tagb_q.neg <= {sa_q.npx == sa_q.ncr, sa_q.npy != sa_q.ncr,
                     sa_q.npx, !sa_q.npy, sa_q.npy, sa_q.npx};
    end
  end

  assign num[0] = NumW'({mpxb_q, {FracW{1'b0}}});
  assign num[1] = NumW'({mpyb_q, {FracW{1'b0}}});
  assign num[2] = NumW'({mpyb_q, {(2*FracW){1'b0}}});
  assign num[3] = NumW'({mpxb_q, {(2*FracW){1'b0}}});
  assign num[4] = {nyb_q, {FracW{1'b0}}};
  assign num[5] = {nxb_q, {FracW{1'b0}}};
  assign den[0] = DenW'(sqb_q);
  assign den[1] = DenW'(sqb_q);
  assign den[2] = DenW'(r2b_q);
  assign den[3] = DenW'(r2b_q);
  assign den[4] = denb_q;
  assign den[5] = denb_q;

  for (genvar e = 0; e < 6; e++) begin : g_div
    rmj_div u_div (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .num_i (num[e]),
      .den_i (den[e]),
      .quo_o (quo[e]),
      .ovf_o (ovf[e])
    );
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dtag_q[0] <= tagb_q;
      for (int j = 1; j < DivLat; j++) begin
        dtag_q[j] <= dtag_q[j-1];
      end
    end
  end

  // Saturate, sign and zero on a too-close state.
  always_comb begin
    res_d.range_by_px   = sat_f(dtag_q[DivLat-1].neg[0], ovf[0], quo[0]);
    res_d.range_by_py   = sat_f(dtag_q[DivLat-1].neg[1], ovf[1], quo[1]);
    res_d.bearing_by_px = sat_f(dtag_q[DivLat-1].neg[2], ovf[2], quo[2]);
    res_d.bearing_by_py = sat_f(dtag_q[DivLat-1].neg[3], ovf[3], quo[3]);
    res_d.rate_by_px    = sat_f(dtag_q[DivLat-1].neg[4], ovf[4], quo[4]);
    res_d.rate_by_py    = sat_f(dtag_q[DivLat-1].neg[5], ovf[5], quo[5]);
    res_d.too_close     = dtag_q[DivLat-1].tc;
    if (dtag_q[DivLat-1].tc) begin
      res_d.range_by_px   = '0;
      res_d.range_by_py   = '0;
      res_d.bearing_by_px = '0;
      res_d.bearing_by_py = '0;
      res_d.rate_by_px    = '0;
      res_d.rate_by_py    = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      res_q <= res_d;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      res_vq <= 1'b0;
      for (int j = 0; j < SqrtSteps; j++) begin
        sv_q[j] <= 1'b0;
      end
      for (int j = 0; j < DivLat; j++) begin
        dv_q[j] <= 1'b0;
      end
    end else if (pipe_en) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      sv_q[0] <= v3_q;
      for (int j = 1; j < SqrtSteps; j++) begin
        sv_q[j] <= sv_q[j-1];
      end
      va_q    <= sv_q[SqrtSteps-1];
      vb_q    <= va_q;
      dv_q[0] <= vb_q;
      for (int j = 1; j < DivLat; j++) begin
        dv_q[j] <= dv_q[j-1];
      end
      res_vq  <= dv_q[DivLat-1];
    end
  end

  // Output register plus one skid slot: the pipe moves while the slot is
  // empty, so a beat leaving the pipe always has a place to land.
  logic take, incoming;
  assign take     = out_vq && out_ready_i;
  assign incoming = pipe_en && res_vq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else if (!out_vq || take) begin
      out_vq  <= skid_vq || incoming;
      skid_vq <= 1'b0;
    end else if (incoming) begin
      skid_vq <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vq || take) begin
      out_q <= skid_vq ? skid_q : res_q;
    end else if (incoming) begin
      skid_q <= res_q;
    end
  end

  assign out_valid_o = out_vq;
  assign out_data_o  = out_q;

endmodule

[rtl/core/rmj_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rmj_sqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [rmj_pkg::RadW-1:0]  rad_i,
  output logic [rmj_pkg::DataW-1:0] root_o
);
  import rmj_pkg::*;

  logic [RadW-1:0] rem_q [0:SqrtSteps-2];
  logic [RadW-1:0] res_q [0:SqrtSteps-1];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_step
    localparam logic [RadW-1:0] Bit = RadW'(1) << (RadW - 2 - 2 * k);
    logic [RadW-1:0] rem_in, res_in, trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign res_in = res_q[k-1];
    end

    assign trial = res_in + Bit;
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        res_q[k] <= ge ? ((res_in >> 1) + Bit) : (res_in >> 1);
      end
    end

    if (k < SqrtSteps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root_o = res_q[SqrtSteps-1][DataW-1:0];

endmodule

[rtl/core/rmj_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps
module rmj_div (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [rmj_pkg::NumW-1:0] num_i,
  input  logic [rmj_pkg::DenW-1:0] den_i,
  output logic [rmj_pkg::QuoW-1:0] quo_o,
  output logic                     ovf_o
);
  import rmj_pkg::*;

  logic [RemW-1:0] rem_q [0:QuoW-1];
  logic [DenW-1:0] den_q [0:QuoW-1];
  logic [QuoW-1:0] quo_q [1:QuoW];
  logic            ovf_q [0:QuoW];

  // Flag quotients that do not fit in QuoW bits.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RemW'(num_i);
      den_q[0] <= den_i;
      ovf_q[0] <= (RemW'(num_i) >= {den_i, {QuoW{1'b0}}});
    end
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_step
    localparam int unsigned Sh = QuoW - k;
    logic [RemW-1:0] cmp;
    logic [QuoW-1:0] quo_in;
    logic            ge;

    if (k == 1) begin : g_first
      assign quo_in = '0;
    end else begin : g_next
      assign quo_in = quo_q[k-1];
    end

    assign cmp = RemW'(den_q[k-1]) << Sh;
    assign ge  = (rem_q[k-1] >= cmp);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[k] <= ge ? (quo_in | (QuoW'(1) << Sh)) : quo_in;
        ovf_q[k] <= ovf_q[k-1];
      end
    end

    if (k < QuoW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? (rem_q[k-1] - cmp) : rem_q[k-1];
          den_q[k] <= den_q[k-1];
        end
      end
    end
  end

  assign quo_o = quo_q[QuoW];
  assign ovf_o = ovf_q[QuoW];

endmodule
